[sv/prime_square_test_macros.svh]
// ----------------------------------------------------------------------------
// prime_square_test_macros.svh
// Assertion macros shared by the prime square test block.
// ----------------------------------------------------------------------------
`ifndef PRIME_SQUARE_TEST_MACROS_SVH
`define PRIME_SQUARE_TEST_MACROS_SVH

// Check cons in the same cycle as ante.
`define PST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define PST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check cons a fixed number of cycles after ante.
`define PST_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

[sv/pst_pkg.sv]
// ----------------------------------------------------------------------------
// pst_pkg
// Widths and interface types of the prime square test block.
// ----------------------------------------------------------------------------
package pst_pkg;

    // Input value and its integer square root
    localparam int VALUE_W   = 40;
    localparam int ROOT_W    = VALUE_W / 2;
    // Remainder and partial root width inside the root pipeline
    localparam int REM_W     = VALUE_W + 1;
    // Largest number of roots a 40-bit value can have
    localparam int MAX_ROOTS = 1 << ROOT_W;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [ROOT_W-1:0]  t_root;
    typedef logic [REM_W-1:0]   t_rem;

    // Lookup request from the query path into the bitmap
    typedef struct packed {
        logic  vld;
        t_root root;
    } t_map_req;

    // Bitmap status back to the query path
    typedef struct packed {
        logic done;       // sieve finished, lookups allowed
        logic composite;  // registered lookup result: root is not prime
    } t_map_stat;

endpackage

[sv/pst_sqrt.sv]
// ----------------------------------------------------------------------------
// pst_sqrt
// Pipelined exact integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module pst_sqrt import pst_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    input  t_value i_value,
    output logic   o_vld,
    output t_root  o_root,
    output logic   o_is_square
);

    t_rem r_rem  [ROOT_W];
    t_rem r_root [ROOT_W];
    logic r_vld  [ROOT_W];

    genvar s;
    generate
        for (s = 0; s < ROOT_W; s++) begin : g_stage
            localparam t_rem BIT = t_rem'(1) << (2 * (ROOT_W - 1 - s));
            t_rem rem_in, root_in, trial;
            logic vld_in, take;

            // Take the previous stage, or the new transaction at the first stage
            if (s == 0) begin : g_first
                assign rem_in  = t_rem'(i_value);
                assign root_in = '0;
                assign vld_in  = i_vld;
            end else begin : g_next
                assign rem_in  = r_rem[s-1];
                assign root_in = r_root[s-1];
                assign vld_in  = r_vld[s-1];
            end

            // Try to subtract the next root bit
            assign trial = root_in + BIT;
            assign take  = (rem_in >= trial);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else begin
                    r_vld[s] <= vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[s]  <= take ? (rem_in - trial) : rem_in;
                r_root[s] <= take ? ((root_in >> 1) + BIT) : (root_in >> 1);
            end
        end
    endgenerate

    // Zero remainder means the value is a perfect square
    assign o_vld       = r_vld[ROOT_W-1];
    assign o_root      = r_root[ROOT_W-1][ROOT_W-1:0];
    assign o_is_square = (r_rem[ROOT_W-1] == '0);

endmodule

[sv/pst_map.sv]
// ----------------------------------------------------------------------------
// pst_map
// Composite bitmap memory with the sieve sequencer that fills it.
// ----------------------------------------------------------------------------
module pst_map import pst_pkg::*; #(
    parameter int ROOT_LIMIT = 1048576
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_map_req  i_req,
    output t_map_stat o_stat
);

    // Roots of a 40-bit value never exceed MAX_ROOTS, so cap the map there
    localparam int MAP_DEPTH = (ROOT_LIMIT < MAX_ROOTS) ? ROOT_LIMIT : MAX_ROOTS;
    localparam int AW        = $clog2(MAP_DEPTH);
    localparam int PW        = 2 * AW;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_SCAN,
        S_TEST,
        S_MARK,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_i, n_i;
    logic [AW:0]   r_j, n_j;
    logic          r_done, n_done;

    logic [PW-1:0] sq_i;
    logic [AW:0]   j_next;

    logic          mem [MAP_DEPTH];
    logic          wr_en, wr_data, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          in_range;
    logic          r_rd_bit, r_in_range;

    assign sq_i     = PW'(r_i) * PW'(r_i);
    assign j_next   = r_j + (AW+1)'(r_i);
    assign in_range = ({1'b0, i_req.root} < (ROOT_W+1)'(MAP_DEPTH));

    // Sequence the clearing pass, the prime scan and the multiple marking
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_done  = r_done;
        wr_en   = 1'b0;
        wr_addr = r_j[AW-1:0];
        wr_data = 1'b1;
        rd_en   = 1'b0;
        rd_addr = i_req.root[AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                // Zero and one are marked composite during the clear
                wr_en   = 1'b1;
                wr_data = (r_j < (AW+1)'(2));
                n_j     = r_j + (AW+1)'(1);
                if (r_j == (AW+1)'(MAP_DEPTH - 1)) begin
                    n_state = S_SCAN;
                    n_i     = AW'(2);
                end
            end
            S_SCAN: begin
                if (sq_i >= PW'(MAP_DEPTH)) begin
                    n_state = S_DONE;
                    n_done  = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_i;
                    n_j     = sq_i[AW:0];
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (r_rd_bit) begin
                    n_i     = r_i + AW'(1);
                    n_state = S_SCAN;
                end else begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                wr_en = 1'b1;
                n_j   = j_next;
                if (j_next >= (AW+1)'(MAP_DEPTH)) begin
                    n_i     = r_i + AW'(1);
                    n_state = S_SCAN;
                end
            end
            S_DONE: begin
                rd_en = i_req.vld;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_i     <= '0;
            r_j     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_done  <= n_done;
        end
    end

    // Write port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, shared by the scan and the lookups
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_bit   <= mem[rd_addr];
            r_in_range <= in_range;
        end
    end

    // Treat a root beyond the map as not prime
    assign o_stat.done      = r_done;
    assign o_stat.composite = r_rd_bit | !r_in_range;

endmodule

[sv/prime_square_test.sv]
// ----------------------------------------------------------------------------
// prime_square_test
// Reports whether a 40-bit unsigned value is the square of a prime.
//
// Input channel: drive i_value with start high; the transaction is taken at
// a rising edge where start is high and busy is low. Once busy is low, one
// transaction per cycle is accepted back to back.
// Result channel: o_valid is high for exactly one cycle with o_is_square and
// o_is_prime_square, and results come out in order. The receiver cannot
// stall; every result must be taken as it comes.
// Latency is set by the 20-stage root pipeline, one bitmap read and the
// output register; throughput is one transaction per cycle while busy is low.
// After reset busy stays high while the bitmap is cleared (one entry per
// cycle) and then sieved; busy then drops and stays low.
// ----------------------------------------------------------------------------
`include "prime_square_test_macros.svh"

module prime_square_test import pst_pkg::*; #(
    parameter int ROOT_LIMIT = 1048576
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    input  t_value i_value,
    output logic   busy,
    output logic   o_valid,
    output logic   o_is_square,
    output logic   o_is_prime_square
);

    localparam int LAT = ROOT_W + 2;

    logic      accept;
    logic      sq_vld, sq_is_square;
    t_root     sq_root;
    t_map_req  map_req;
    t_map_stat map_stat;

    logic      r_lk_vld, r_lk_sq;
    logic      r_valid, r_is_square, r_is_prime_square;

    assign busy   = !map_stat.done;
    assign accept = start && !busy;

    pst_sqrt u_sqrt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (accept),
        .i_value     (i_value),
        .o_vld       (sq_vld),
        .o_root      (sq_root),
        .o_is_square (sq_is_square)
    );

    // Look the root up in the bitmap
    assign map_req.vld  = sq_vld;
    assign map_req.root = sq_root;

    pst_map #(
        .ROOT_LIMIT (ROOT_LIMIT)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_req),
        .o_stat  (map_stat)
    );

    // Align the square flag with the bitmap read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lk_vld <= 1'b0;
        end else begin
            r_lk_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lk_sq <= sq_is_square;
    end

    // Register the result transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_lk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_square       <= r_lk_sq;
        r_is_prime_square <= r_lk_sq & !map_stat.composite;
    end

    assign o_valid           = r_valid;
    assign o_is_square       = r_is_square;
    assign o_is_prime_square = r_is_prime_square;

    // Assertions
    `PST_ASSERT_NOW(a_no_result_while_busy, o_valid, !busy, "result during sieve")
    `PST_ASSERT_NEXT(a_busy_stays_low, !busy, !busy, "busy rose after sieve")
    `PST_ASSERT_DELAY(a_result_latency, accept, LAT, o_valid, "result missing")
    `PST_ASSERT_NOW(a_prime_implies_square, o_valid && o_is_prime_square, o_is_square,
        "prime square flagged on non-square")

endmodule

[tb/prime_square_test_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_square_test_test
// Self-checking bench for the prime square detector. A local sieve and an
// exact integer root predict both flags for every accepted transaction; the
// monitor compares each strobed result, in order, against those predictions.
// Stimulus is a directed set of edge values followed by random prime
// squares, composite squares, near squares and raw 40-bit values, sent in
// bursts with random gaps, draining fully before the random part and midway.
// ----------------------------------------------------------------------------
module prime_square_test_test import pst_pkg::*;;

    localparam int     ROOT_CAP     = 1048576;
    localparam int     RANDOM_ITEMS = 900;
    localparam int     TAIL_CYCLES  = 40;
    // Watchdog limit; leaves wide headroom over the clear and the sieve
    localparam longint CYCLE_LIMIT  = 20_000_000;

    typedef struct {
        t_value value;
        bit     wait_drain;
    } t_query;

    typedef struct {
        t_value value;
        logic   is_square;
        logic   is_prime_square;
    } t_flags;

    logic   i_clk   = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start   = 1'b0;
    t_value i_value = '0;
    logic   busy;
    logic   o_valid;
    logic   o_is_square;
    logic   o_is_prime_square;

    bit     composite_root [ROOT_CAP];
    t_query queries [$];
    t_flags flags_expected [$];

    int     n_accepted = 0;
    int     n_checked  = 0;
    int     n_fail     = 0;
    int     n_square   = 0;
    int     n_prime_sq = 0;
    int     burst_left = 0;
    int     gap_left   = 0;
    longint n_cycles   = 0;

    prime_square_test #(
        .ROOT_LIMIT(ROOT_CAP)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .i_value          (i_value),
        .busy             (busy),
        .o_valid          (o_valid),
        .o_is_square      (o_is_square),
        .o_is_prime_square(o_is_prime_square)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Floor of the square root, one result bit at a time from the top
    function automatic t_root root_floor(t_value v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= {24'd0, v}) root = trial;
        end
        return root[ROOT_W-1:0];
    endfunction

    function automatic t_flags predict_flags(t_value v);
        t_root       r;
        logic [63:0] r64;
        t_flags      f;
        r   = root_floor(v);
        r64 = {44'd0, r};
        f.value           = v;
        f.is_square       = (r64 * r64 == {24'd0, v});
        f.is_prime_square = f.is_square && (r64 < ROOT_CAP) && !composite_root[r];
        return f;
    endfunction

    function automatic t_value square_of(longint r);
        return t_value'(r * r);
    endfunction

    task automatic add_query(t_value v, bit drain);
        t_query q;
        q.value      = v;
        q.wait_drain = drain;
        queries.insert(queries.size(), q);
    endtask

    // Driver: present queued transactions in bursts, hold while busy
    always @(posedge i_clk) begin
        int accepted_now;
        accepted_now = n_accepted;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                flags_expected.insert(flags_expected.size(), predict_flags(i_value));
                void'(queries.pop_front());
                accepted_now = n_accepted + 1;
                n_accepted <= accepted_now;
            end
            if (start && busy) begin
                // hold the offered transaction until taken
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (queries.size() == 0) begin
                start <= 1'b0;
            end else if (queries[0].wait_drain && n_checked != accepted_now) begin
                // drop start until every outstanding result is back
                start <= 1'b0;
            end else begin
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 20);
                end
                start   <= 1'b1;
                i_value <= queries[0].value;
                burst_left--;
                if (burst_left == 0) begin
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                           : $urandom_range(1, 4);
                end
            end
        end
    end

    // Monitor: check each strobed result against the oldest prediction
    always @(posedge i_clk) begin
        t_flags want;
        if (i_rst_n && o_valid) begin
            if (n_checked >= n_accepted) begin
                n_fail++;
                if (n_fail <= 10) begin
                    $display("ERROR: result with no transaction pending: sq=%0b psq=%0b",
                             o_is_square, o_is_prime_square);
                end
            end else begin
                want = flags_expected[n_checked];
                n_checked <= n_checked + 1;
                if (want.is_square) n_square++;
                if (want.is_prime_square) n_prime_sq++;
                if (o_is_square !== want.is_square ||
                    o_is_prime_square !== want.is_prime_square) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("ERROR: value %0d: expected sq=%0b psq=%0b, got sq=%0b psq=%0b",
                                 want.value, want.is_square, want.is_prime_square,
                                 o_is_square, o_is_prime_square);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        longint i;
        longint j;
        longint r;
        longint p_top;
        int     kind;
        t_value v;

        // Local sieve over all roots
        composite_root[0] = 1'b1;
        composite_root[1] = 1'b1;
        for (i = 2; i * i < ROOT_CAP; i++) begin
            if (!composite_root[i]) begin
                for (j = i * i; j < ROOT_CAP; j += i) composite_root[j] = 1'b1;
            end
        end
        p_top = ROOT_CAP - 1;
        while (composite_root[p_top]) p_top--;

        // Directed: zero and one, small squares, near squares, extremes
        add_query(40'd0, 1'b0);
        add_query(40'd1, 1'b0);
        add_query(40'd2, 1'b0);
        add_query(40'd3, 1'b0);
        add_query(40'd4, 1'b0);
        add_query(40'd5, 1'b0);
        add_query(40'd8, 1'b0);
        add_query(40'd9, 1'b0);
        add_query(40'd16, 1'b0);
        add_query(40'd25, 1'b0);
        add_query(40'd49, 1'b0);
        add_query(40'd121, 1'b0);
        add_query({40{1'b1}}, 1'b0);
        add_query(square_of(ROOT_CAP - 1), 1'b0);
        add_query(square_of(p_top), 1'b0);
        add_query(square_of(p_top) - 40'd1, 1'b0);
        add_query(square_of(p_top) + 40'd1, 1'b0);
        add_query(40'd1 << 39, 1'b0);
        add_query(40'd1 << 38, 1'b0);
        add_query(40'h55_5555_5555, 1'b0);
        add_query(40'hAA_AAAA_AAAA, 1'b0);

        // Random mix; drain before the first random item and at the midpoint
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            kind = $urandom_range(0, 99);
            r = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 1000))
                                            : longint'($urandom_range(0, ROOT_CAP - 1));
            if (kind < 30) begin
                while (r < ROOT_CAP && composite_root[r]) r++;
                if (r >= ROOT_CAP) r = 2;
                v = square_of(r);
            end else if (kind < 50) begin
                v = square_of(r);
            end else if (kind < 65) begin
                v = $urandom_range(0, 1) ? square_of(r) + 40'd1 : square_of(r) - 40'd1;
            end else if (kind < 75) begin
                v = t_value'($urandom_range(0, 1000));
            end else begin
                v = {8'($urandom_range(0, 255)), 32'($urandom())};
            end
            add_query(v, (n == 0) || (n == RANDOM_ITEMS / 2));
        end

        // Release reset
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all transactions, all results, then a short tail
        wait (queries.size() == 0);
        wait (n_checked == n_accepted);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_checked != n_accepted) n_fail++;
        $display("Checked %0d transactions after the sieve: %0d squares, %0d prime squares.",
                 n_checked, n_square, n_prime_sq);
        $display("Failures: %0d", n_fail);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
